@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the contact and marker pixel mask.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CMPM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define CMPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CMPM_ASSERT_SAME(lbl, ante, cons)
`define CMPM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/cmpm_pkg.sv @@
// Package for the contact and marker pixel mask: register indexes, reset values,
// field widths, the pixel struct and max/min helper functions. No dependencies.
`timescale 1ns / 1ps

package cmpm_pkg;

    localparam int PIX_W        = 8;
    localparam int BORDER_W     = 11;
    localparam int FRAME_SIZE_W = 13;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_MARKER_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MARKER_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTACT_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTACT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

    localparam logic [PIX_W-1:0]        RST_MARKER_LOW   = 8'd0;
    localparam logic [PIX_W-1:0]        RST_MARKER_HIGH  = 8'd0;
    localparam logic [PIX_W-1:0]        RST_CONTACT_HIGH = 8'd255;
    localparam logic [PIX_W-1:0]        RST_CONTACT_LOW  = 8'd255;
    localparam logic [BORDER_W-1:0]     RST_BORDER       = 11'd0;
    localparam logic [FRAME_SIZE_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [FRAME_SIZE_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    typedef struct packed {
        logic [PIX_W-1:0] ref_red;
        logic [PIX_W-1:0] ref_green;
        logic [PIX_W-1:0] ref_blue;
        logic [PIX_W-1:0] cur_red;
        logic [PIX_W-1:0] cur_green;
        logic [PIX_W-1:0] cur_blue;
    } pixel_t;

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [PIX_W-1:0] pos_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

endpackage

@@ sv/contact_and_marker_pixel_mask.sv @@
// Contact and marker pixel mask: classifies raster-order pixels against thresholds.
// Throughput one beat per cycle while the output side does not stall.
// Input register, combinational classify, result register; stalls propagate back.
// aresetn (synchronous, active low) clears counters and valid flags, loads register defaults.
// Depends on cmpm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module contact_and_marker_pixel_mask
    import cmpm_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // cfg_index selects the register, cfg_data carries its value in the low bits
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // tdata: cur_blue, cur_green, cur_red, ref_blue, ref_green, ref_red
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [6*PIX_W-1:0]    s_tdata,
    // tdata: contact, marker, six zero bits; tlast: frame_end
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);

    localparam int CW  = $clog2(MAX_DIMENSION);
    localparam int SW  = $clog2(MAX_DIMENSION + 1);
    localparam int AW0 = (SW > FRAME_SIZE_W) ? SW : FRAME_SIZE_W;
    localparam int AW  = AW0 + 1;

    logic [PIX_W-1:0]        marker_low_reg, marker_high_reg;
    logic [PIX_W-1:0]        contact_high_reg, contact_low_reg;
    logic [BORDER_W-1:0]     border_reg;
    logic [FRAME_SIZE_W-1:0] frame_width_reg, frame_height_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;

    logic          s1_valid_reg;
    pixel_t        s1_pix_reg;
    logic [CW-1:0] s1_col_reg, s1_row_reg;

    logic m_valid_reg, contact_reg, marker_reg, last_reg;

    logic          in_acc, s1_adv;
    logic [AW-1:0] w_eff, h_eff, b_ext, c_ext, r_ext, c_inc, r_inc;
    logic          in_window, marker, contact, last;
    logic [PIX_W-1:0] hi, lo, up_max, down_max;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_low_reg   <= RST_MARKER_LOW;
            marker_high_reg  <= RST_MARKER_HIGH;
            contact_high_reg <= RST_CONTACT_HIGH;
            contact_low_reg  <= RST_CONTACT_LOW;
            border_reg       <= RST_BORDER;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MARKER_LOW:   marker_low_reg   <= cfg_data[PIX_W-1:0];
                REG_MARKER_HIGH:  marker_high_reg  <= cfg_data[PIX_W-1:0];
                REG_CONTACT_HIGH: contact_high_reg <= cfg_data[PIX_W-1:0];
                REG_CONTACT_LOW:  contact_low_reg  <= cfg_data[PIX_W-1:0];
                REG_BORDER:       border_reg       <= cfg_data[BORDER_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp frame sizes: zero acts as one, oversize as the maximum
    always_comb begin
        w_eff = AW'(frame_width_reg);
        if (w_eff == '0)
            w_eff = AW'(1);
        else if (w_eff > AW'(MAX_DIMENSION))
            w_eff = AW'(MAX_DIMENSION);
        h_eff = AW'(frame_height_reg);
        if (h_eff == '0)
            h_eff = AW'(1);
        else if (h_eff > AW'(MAX_DIMENSION))
            h_eff = AW'(MAX_DIMENSION);
    end

    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_acc   = s_tvalid && s_tready;

    always_comb begin
        c_inc    = AW'(col_reg) + AW'(1);
        r_inc    = AW'(row_reg) + AW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc) begin
            if (c_inc >= w_eff) begin
                col_next = '0;
                row_next = (r_inc >= h_eff) ? '0 : r_inc[CW-1:0];
            end else begin
                col_next = c_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (s_tready)
                s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_pix_reg <= pixel_t'(s_tdata);
            s1_col_reg <= col_reg;
            s1_row_reg <= row_reg;
        end
    end

    always_comb begin
        b_ext    = AW'(border_reg);
        c_ext    = AW'(s1_col_reg);
        r_ext    = AW'(s1_row_reg);
        in_window = (c_ext >= b_ext) && ((c_ext + b_ext) < w_eff) &&
                    (r_ext >= b_ext) && ((r_ext + b_ext) < h_eff);
        hi       = max3(s1_pix_reg.cur_blue, s1_pix_reg.cur_green, s1_pix_reg.cur_red);
        lo       = min3(s1_pix_reg.cur_blue, s1_pix_reg.cur_green, s1_pix_reg.cur_red);
        up_max   = max3(pos_diff(s1_pix_reg.cur_blue,  s1_pix_reg.ref_blue),
                        pos_diff(s1_pix_reg.cur_green, s1_pix_reg.ref_green),
                        pos_diff(s1_pix_reg.cur_red,   s1_pix_reg.ref_red));
        down_max = max3(pos_diff(s1_pix_reg.ref_blue,  s1_pix_reg.cur_blue),
                        pos_diff(s1_pix_reg.ref_green, s1_pix_reg.cur_green),
                        pos_diff(s1_pix_reg.ref_red,   s1_pix_reg.cur_red));
        marker   = in_window && (lo < marker_low_reg) && (hi < marker_high_reg);
        contact  = in_window && !marker && (up_max >= contact_high_reg) &&
                   (down_max >= contact_low_reg);
        last     = (c_ext == (w_eff - AW'(1))) && (r_ext == (h_eff - AW'(1)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            contact_reg <= contact;
            marker_reg  <= marker;
            last_reg    <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, marker_reg, contact_reg};
    assign m_tlast  = last_reg;

    `CMPM_ASSERT_SAME(a_mark_excl_contact, m_valid_reg, !(marker_reg && contact_reg))
    `CMPM_ASSERT_NEXT(a_frame_wrap,
        in_acc && (AW'(col_reg) == w_eff - AW'(1)) && (AW'(row_reg) == h_eff - AW'(1)),
        (col_reg == '0) && (row_reg == '0))
    `CMPM_ASSERT_NEXT(a_stage_hold, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_col_reg))
    `CMPM_ASSERT_NEXT(a_result_hold, m_valid_reg && !m_tready, m_valid_reg && $stable(m_tdata))

endmodule
